// ===== hw/rtl/dcq_pkg.sv =====
// shared constants for the two-queue slot array block
// command, queue select and status codes, default sizes
// no dependencies
package dcq_pkg;

	localparam int TOTAL_SLOTS_DEF = 16;
	localparam int DATA_BITS_DEF   = 32;

	localparam logic [1:0] CMD_INSERT  = 2'd0;
	localparam logic [1:0] CMD_DELETE  = 2'd1;
	localparam logic [1:0] CMD_DISPLAY = 2'd2;
	localparam logic [1:0] CMD_NONE    = 2'd3;

	localparam logic [1:0] QID_ONE = 2'd1;
	localparam logic [1:0] QID_TWO = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_BADQ  = 2'd3;

endpackage

// ===== hw/rtl/dual_circular_queue_shared_buffer_unit.sv =====
// two circular queues kept in one slot array, with a pointer-advance unit
// shared by insert, delete and display under a two-state sequencer
// depends on dcq_pkg
//
// A request is taken when start is high and busy is low. Insert, and any
// request that fails (full, empty, invalid queue), gives its single result
// on the result ports, marked by strobe, in the next cycle, and busy stays
// low so one such request can be taken every cycle. Delete reads one element
// and display reads every element of the queue, one element per cycle,
// as every element goes through the single registered read port of the
// slot array and through the one shared pointer-advance unit; busy is high
// from the cycle after acceptance until the last read is done. Each result is
// shown for exactly one cycle and the receiver cannot stall the block: it must
// take every strobe. Command 3 is dropped without a result. The slot array has
// no reset; only slots written by an insert are ever read.
module dual_circular_queue_shared_buffer_unit #(
	parameter int TOTAL_SLOTS = dcq_pkg::TOTAL_SLOTS_DEF,
	parameter int DATA_BITS   = dcq_pkg::DATA_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  command,
	input  logic [1:0]                  queue_id,
	input  logic signed [DATA_BITS-1:0] value,
	output logic                        strobe,
	output logic [1:0]                  status,
	output logic signed [DATA_BITS-1:0] data,
	output logic                        last
);

	localparam int PW = $clog2(TOTAL_SLOTS);
	localparam int R1 = TOTAL_SLOTS / 2 + 1;
	localparam logic [PW:0]   END_ONE  = (PW + 1)'(R1);
	localparam logic [PW:0]   END_TWO  = (PW + 1)'(TOTAL_SLOTS);
	localparam logic [PW-1:0] BASE_ONE = '0;
	localparam logic [PW-1:0] BASE_TWO = PW'(R1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t state_q;

	logic [DATA_BITS-1:0] mem [TOTAL_SLOTS];

	logic [PW-1:0] head_one_q, tail_one_q, head_two_q, tail_two_q;
	logic [PW-1:0] ptr_q;
	logic          two_q;
	logic          disp_q;

	logic                 strobe_q;
	logic [1:0]           status_q;
	logic [DATA_BITS-1:0] data_q;
	logic                 last_q;

	logic          accept;
	logic          sel_two;
	logic          qid_ok;
	logic [PW-1:0] head_sel, tail_sel;

	// shared pointer-advance unit
	logic [PW-1:0] adv_in;
	logic          adv_two;
	logic [PW:0]   adv_sum;
	logic [PW-1:0] adv_out;

	assign accept  = start && (state_q == S_IDLE);
	assign sel_two = (state_q == S_READ) ? two_q : (queue_id == dcq_pkg::QID_TWO);
	assign qid_ok  = (queue_id == dcq_pkg::QID_ONE) || (queue_id == dcq_pkg::QID_TWO);

	assign head_sel = sel_two ? head_two_q : head_one_q;
	assign tail_sel = sel_two ? tail_two_q : tail_one_q;

	always_comb begin
		adv_two = sel_two;
		if (state_q == S_READ) begin
			adv_in = ptr_q;
		end else if (command == dcq_pkg::CMD_INSERT) begin
			adv_in = tail_sel;
		end else begin
			adv_in = head_sel;
		end
		adv_sum = {1'b0, adv_in} + (PW + 1)'(1);
		if (adv_sum == (adv_two ? END_TWO : END_ONE)) begin
			adv_out = adv_two ? BASE_TWO : BASE_ONE;
		end else begin
			adv_out = adv_sum[PW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_one_q <= BASE_ONE;
			tail_one_q <= BASE_ONE;
			head_two_q <= BASE_TWO;
			tail_two_q <= BASE_TWO;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && command != dcq_pkg::CMD_NONE) begin
						if (!qid_ok) begin
							strobe_q <= 1'b1;
						end else if (command == dcq_pkg::CMD_INSERT) begin
							strobe_q <= 1'b1;
							if (adv_out != head_sel) begin
								if (sel_two) begin
									tail_two_q <= adv_out;
								end else begin
									tail_one_q <= adv_out;
								end
							end
						end else if (head_sel == tail_sel) begin
							strobe_q <= 1'b1;
						end else begin
							state_q <= S_READ;
							if (command == dcq_pkg::CMD_DELETE) begin
								if (sel_two) begin
									head_two_q <= adv_out;
								end else begin
									head_one_q <= adv_out;
								end
							end
						end
					end
				end
				S_READ: begin
					strobe_q <= 1'b1;
					if (!disp_q || ptr_q == tail_sel) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload side: pointer, flags, result fields, slot array
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				ptr_q    <= adv_out;
				two_q    <= sel_two;
				disp_q   <= (command == dcq_pkg::CMD_DISPLAY);
				data_q   <= '0;
				last_q   <= 1'b1;
				if (!qid_ok) begin
					status_q <= dcq_pkg::ST_BADQ;
				end else if (command == dcq_pkg::CMD_INSERT) begin
					if (adv_out == head_sel) begin
						status_q <= dcq_pkg::ST_FULL;
					end else begin
						status_q <= dcq_pkg::ST_OK;
						if (accept) begin
							mem[adv_out] <= value;
						end
					end
				end else if (head_sel == tail_sel) begin
					status_q <= dcq_pkg::ST_EMPTY;
				end else begin
					status_q <= dcq_pkg::ST_OK;
				end
			end
			S_READ: begin
				data_q   <= mem[ptr_q];
				status_q <= dcq_pkg::ST_OK;
				last_q   <= !disp_q || (ptr_q == tail_sel);
				ptr_q    <= adv_out;
			end
			default: begin
				data_q <= '0;
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign status = status_q;
	assign data   = data_q;
	assign last   = last_q;

	a_read_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |=> strobe_q)
		else $error("read cycle without a result");

	a_run_holds_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && !last_q) |-> busy)
		else $error("display run ended before its last element");

	a_insert_single: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == dcq_pkg::CMD_INSERT) |=>
		(strobe_q && last_q && status_q != dcq_pkg::ST_EMPTY && !busy))
		else $error("insert did not give one result");

	a_region_one: assert property (@(posedge clk) disable iff (!arst_n)
		(head_one_q < BASE_TWO) && (tail_one_q < BASE_TWO))
		else $error("queue one pointer left its region");

	a_region_two: assert property (@(posedge clk) disable iff (!arst_n)
		(head_two_q >= BASE_TWO) && (tail_two_q >= BASE_TWO))
		else $error("queue two pointer left its region");

endmodule
